@@ rtl/m4inv_pkg.sv @@
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared widths, state encoding and the minor index helper for the 4x4
// fixed-point inverse.
// ----------------------------------------------------------------------------
package m4inv_pkg;

    localparam int ELEM_W = 15;
    localparam int OUT_W  = 32;
    localparam int COF_W  = 46;
    localparam int DET_W  = 62;
    localparam int ACC_W  = 64;
    localparam int NELEM  = 16;
    localparam int OUT_FRAC = 16;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_COF,
        ST_DET,
        ST_DIV,
        ST_OUT,
        ST_SING
    } t_state;

    // indices of the three rows or columns kept when index skip is removed
    function automatic logic [1:0] keep_idx(input logic [1:0] skip, input logic [1:0] n);
        logic [2:0] v;
        v = {1'b0, n};
        if (v >= {1'b0, skip}) v = v + 3'd1;
        return v[1:0];
    endfunction

endpackage

@@ rtl/m4inv_if.sv @@
// ----------------------------------------------------------------------------
// m4inv_in_if / m4inv_out_if
// Valid/ready channels for matrix elements and inverse results.
// ----------------------------------------------------------------------------
interface m4inv_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [m4inv_pkg::ELEM_W-1:0]    elem_value;
    modport source (output valid, output elem_value, input ready);
    modport sink   (input valid, input elem_value, output ready);
endinterface

interface m4inv_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [m4inv_pkg::OUT_W-1:0]     inv_value;
    logic                                   singular;
    logic                                   last_out;
    modport source (output valid, output inv_value, output singular, output last_out,
                    input ready);
    modport sink   (input valid, input inv_value, input singular, input last_out,
                    output ready);
endinterface

@@ rtl/m4inv_div.sv @@
// ----------------------------------------------------------------------------
// m4inv_div
// Bit-serial scaled divider: trunc(|n| * 2^SH / |d|), saturated to Q16.16,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module m4inv_div #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [m4inv_pkg::COF_W-1:0]   i_num,
    input  logic signed [m4inv_pkg::DET_W-1:0]   i_den,
    output logic                                 o_done,
    output logic signed [m4inv_pkg::OUT_W-1:0]   o_quot
);
    localparam int SH    = FRAC_BITS + m4inv_pkg::OUT_FRAC;
    localparam int NB    = m4inv_pkg::COF_W + SH;
    localparam int CNT_W = $clog2(NB + 1);
    localparam int D_W   = m4inv_pkg::DET_W;

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NB-1:0]    r_num, n_num;
    logic [D_W:0]     r_rem, n_rem;
    logic [D_W-1:0]   r_den, n_den;
    logic [33:0]      r_q, n_q;
    logic             r_neg, n_neg;
    logic             r_done, n_done;
    logic [D_W:0]     w_sh;
    logic [33:0]      w_lim;
    logic [33:0]      w_qres;
    logic [m4inv_pkg::COF_W-1:0] w_anum;

    assign w_lim  = r_neg ? 34'h080000000 : 34'h07FFFFFFF;
    assign w_sh   = {r_rem[D_W-1:0], r_num[NB-1]};
    assign w_anum = i_num[m4inv_pkg::COF_W-1] ? m4inv_pkg::COF_W'(-i_num)
                                              : m4inv_pkg::COF_W'(i_num);
    assign w_qres = (r_q > w_lim) ? w_lim : r_q;

    // restoring division, saturating quotient register
    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_num = r_num; n_rem = r_rem;
        n_den = r_den;   n_q = r_q;     n_neg = r_neg; n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NB);
            n_num  = {w_anum, {SH{1'b0}}};
            n_rem  = '0;
            n_den  = i_den[D_W-1] ? D_W'(-i_den) : D_W'(i_den);
            n_q    = '0;
            n_neg  = i_num[m4inv_pkg::COF_W-1] != i_den[D_W-1];
        end else if (r_busy) begin
            n_num = r_num << 1;
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q   = (r_q > w_lim) ? r_q : {r_q[32:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = (r_q > w_lim) ? r_q : {r_q[32:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt; r_num <= n_num; r_rem <= n_rem;
        r_den <= n_den; r_q <= n_q;     r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? m4inv_pkg::OUT_W'(-w_qres) : m4inv_pkg::OUT_W'(w_qres);
endmodule

@@ rtl/matrix4_inverse_cofactor.sv @@
// ----------------------------------------------------------------------------
// matrix4_inverse_cofactor
// 4x4 fixed-point matrix inverse by adjugate over determinant, built on one
// shared multiplier and one bit-serial divider.
// ----------------------------------------------------------------------------
// sequence: sixteen cofactors from the shared multiplier, then the determinant,
//   then one serial divide per output element (FRAC_BITS 8 by default)
// flow: a new matrix is taken only after the last result of the previous one;
//   input ready only while loading; a singular matrix ends with one flagged result
// reset: synchronous active low; element counter and sequencer clear, stores
//   hold undefined contents until written
module matrix4_inverse_cofactor #(
    parameter int FRAC_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    m4inv_in_if.sink     i_elem,
    m4inv_out_if.source  o_inv
);
    localparam int EW = m4inv_pkg::ELEM_W;
    localparam int CW = m4inv_pkg::COF_W;
    localparam int DW = m4inv_pkg::DET_W;
    localparam int PW = CW + EW;

    m4inv_pkg::t_state r_state, n_state;
    logic [3:0]  r_idx, n_idx;      // load count / cofactor / det step / output index
    logic [3:0]  r_stp, n_stp;      // multiply step inside one cofactor
    logic signed [EW-1:0] r_mat [16];
    logic signed [CW-1:0] r_cof [16];
    logic signed [PW-1:0] r_p, n_p;  // first product of a 2x2 term
    logic signed [PW-1:0] r_t0, n_t0, r_t1, n_t1, r_t2, n_t2;
    logic signed [PW-1:0] r_acc, n_acc;
    logic signed [DW-1:0] r_det, n_det;
    logic signed [PW-1:0] r_prod;
    logic signed [CW-1:0] w_ma;
    logic signed [EW-1:0] w_mb;
    logic signed [PW-1:0] w_minor;
    logic signed [CW-1:0] w_cof;
    logic                 w_cof_we;
    logic                 r_div_go, n_div_go;
    logic                 r_ov, n_ov;
    logic signed [m4inv_pkg::OUT_W-1:0] r_oval, n_oval;
    logic                 r_osing, n_osing, r_olast, n_olast;
    logic                 w_div_done;
    logic signed [m4inv_pkg::OUT_W-1:0] w_quot;
    logic [1:0]  w_r, w_c, w_sr, w_sc;
    logic [1:0]  w_r0, w_r1, w_r2, w_c0, w_c1, w_c2;
    logic signed [EW-1:0] w_a00, w_a01, w_a02, w_a10, w_a11, w_a12, w_a20, w_a21, w_a22;

    // adjugate entry (r,c) is the cofactor of element (c,r)
    assign w_r  = r_idx[3:2];
    assign w_c  = r_idx[1:0];
    assign w_sr = w_c;
    assign w_sc = w_r;
    assign w_r0 = m4inv_pkg::keep_idx(w_sr, 2'd0);
    assign w_r1 = m4inv_pkg::keep_idx(w_sr, 2'd1);
    assign w_r2 = m4inv_pkg::keep_idx(w_sr, 2'd2);
    assign w_c0 = m4inv_pkg::keep_idx(w_sc, 2'd0);
    assign w_c1 = m4inv_pkg::keep_idx(w_sc, 2'd1);
    assign w_c2 = m4inv_pkg::keep_idx(w_sc, 2'd2);
    assign w_a00 = r_mat[{w_r0, w_c0}]; assign w_a01 = r_mat[{w_r0, w_c1}];
    assign w_a02 = r_mat[{w_r0, w_c2}]; assign w_a10 = r_mat[{w_r1, w_c0}];
    assign w_a11 = r_mat[{w_r1, w_c1}]; assign w_a12 = r_mat[{w_r1, w_c2}];
    assign w_a20 = r_mat[{w_r2, w_c0}]; assign w_a21 = r_mat[{w_r2, w_c1}];
    assign w_a22 = r_mat[{w_r2, w_c2}];

    // signed minor from the three outer products, sign by adjugate position
    assign w_minor = r_acc + r_prod;
    assign w_cof   = (r_idx[2] ^ r_idx[0]) ? CW'(-w_minor) : CW'(w_minor);

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == m4inv_pkg::ST_DET) begin
            w_ma = r_cof[{r_idx[1:0], 2'd0}];
            w_mb = r_mat[{2'd0, r_idx[1:0]}];
        end else begin
            unique case (r_stp)
                4'd0: begin w_ma = CW'(w_a11); w_mb = w_a22; end
                4'd1: begin w_ma = CW'(w_a12); w_mb = w_a21; end
                4'd2: begin w_ma = CW'(w_a10); w_mb = w_a22; end
                4'd3: begin w_ma = CW'(w_a12); w_mb = w_a20; end
                4'd4: begin w_ma = CW'(w_a10); w_mb = w_a21; end
                4'd5: begin w_ma = CW'(w_a11); w_mb = w_a20; end
                4'd6: begin w_ma = CW'(r_t0);  w_mb = w_a00; end
                4'd7: begin w_ma = CW'(r_t1);  w_mb = w_a01; end
                4'd8: begin w_ma = CW'(r_t2);  w_mb = w_a02; end
                default: begin w_ma = '0;      w_mb = '0;    end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_idx = r_idx; n_stp = r_stp; n_acc = r_acc;
        n_det = r_det; n_p = r_p; n_t0 = r_t0; n_t1 = r_t1; n_t2 = r_t2;
        n_div_go = 1'b0; n_ov = r_ov; w_cof_we = 1'b0;
        n_oval = r_oval; n_osing = r_osing; n_olast = r_olast;
        unique case (r_state)
            m4inv_pkg::ST_LOAD: begin
                if (i_elem.valid) begin
                    n_idx = r_idx + 4'd1;
                    if (r_idx == 4'd15) begin
                        n_state = m4inv_pkg::ST_COF;
                        n_stp = '0;
                    end
                end
            end
            m4inv_pkg::ST_COF: begin
                // products land in r_prod by the next step
                n_stp = r_stp + 4'd1;
                unique case (r_stp)
                    4'd1: n_p  = r_prod;
                    4'd2: n_t0 = r_p - r_prod;
                    4'd3: n_p  = r_prod;
                    4'd4: n_t1 = r_p - r_prod;
                    4'd5: n_p  = r_prod;
                    4'd6: n_t2 = r_p - r_prod;
                    4'd7: n_acc = r_prod;
                    4'd8: n_acc = r_acc - r_prod;
                    4'd9: begin
                        w_cof_we = 1'b1;
                        n_stp = '0;
                        n_idx = r_idx + 4'd1;
                        if (r_idx == 4'd15) begin
                            n_state = m4inv_pkg::ST_DET;
                            n_idx = '0;
                            n_det = '0;
                        end
                    end
                    default: ;
                endcase
            end
            m4inv_pkg::ST_DET: begin
                // products of steps 0..3 are summed in steps 1..4, checked in step 5
                if (r_idx == 4'd5) begin
                    n_idx = '0;
                    if (r_det == '0) begin
                        n_state = m4inv_pkg::ST_SING;
                        n_oval = '0; n_osing = 1'b1; n_olast = 1'b1; n_ov = 1'b1;
                    end else begin
                        n_state = m4inv_pkg::ST_DIV;
                        n_div_go = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 4'd1;
                    if (r_idx != 4'd0) n_det = r_det + DW'(r_prod);
                end
            end
            m4inv_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_oval = w_quot; n_osing = 1'b0;
                    n_olast = (r_idx == 4'd15); n_ov = 1'b1;
                    n_state = m4inv_pkg::ST_OUT;
                end
            end
            m4inv_pkg::ST_OUT: begin
                if (o_inv.ready) begin
                    n_ov = 1'b0;
                    n_idx = r_idx + 4'd1;
                    if (r_idx == 4'd15) begin
                        n_state = m4inv_pkg::ST_LOAD;
                        n_idx = '0;
                    end else begin
                        n_state = m4inv_pkg::ST_DIV;
                        n_div_go = 1'b1;
                    end
                end
            end
            m4inv_pkg::ST_SING: begin
                if (o_inv.ready) begin
                    n_ov = 1'b0;
                    n_idx = '0;
                    n_state = m4inv_pkg::ST_LOAD;
                end
            end
            default: n_state = m4inv_pkg::ST_LOAD;
        endcase
    end

    // state and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= m4inv_pkg::ST_LOAD;
            r_idx    <= '0;
            r_stp    <= '0;
            r_ov     <= 1'b0;
            r_div_go <= 1'b0;
            r_det    <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_stp    <= n_stp;
            r_ov     <= n_ov;
            r_div_go <= n_div_go;
            r_det    <= n_det;
        end
        r_p     <= n_p;
        r_t0    <= n_t0;
        r_t1    <= n_t1;
        r_t2    <= n_t2;
        r_acc   <= n_acc;
        r_oval  <= n_oval;
        r_osing <= n_osing;
        r_olast <= n_olast;
        if (w_cof_we) r_cof[r_idx] <= w_cof;
        if (i_elem.valid && i_elem.ready) r_mat[r_idx] <= i_elem.elem_value;
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) r_prod <= PW'(w_ma) * PW'(w_mb);

    m4inv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_cof[r_idx]),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign i_elem.ready    = (r_state == m4inv_pkg::ST_LOAD);
    assign o_inv.valid     = r_ov;
    assign o_inv.inv_value = r_oval;
    assign o_inv.singular  = r_osing;
    assign o_inv.last_out  = r_olast;

    // checks
    a_no_out_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == m4inv_pkg::ST_LOAD) |-> !o_inv.valid) else $error("output during load");
    a_sing_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_inv.valid && o_inv.singular) |-> o_inv.last_out) else $error("singular not last");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_inv.valid && !o_inv.ready) |=> (o_inv.valid && $stable(o_inv.inv_value)))
        else $error("result dropped");
endmodule
